// ===== rtl/tilt_pkg.sv =====
// Shared types, widths and constants for the accelerometer tilt angle core.
// Holds the sample and result structs and the CORDIC arctangent table.
// No dependencies.
`default_nettype none

package tilt_pkg;

  // Default CORDIC step count and the length of the arctangent table.
  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned ATAN_TABLE_LEN   = 24;

  // Datapath widths.
  localparam int unsigned SUM_W  = 32;  // ax^2 + az^2, at most 2^31
  localparam int unsigned ROOT_W = 32;  // floor(sqrt(sum * 2^32))
  localparam int unsigned REM_W  = 33;  // square root remainder, at most 2 * root
  localparam int unsigned XY_W   = 36;  // CORDIC x and y with gain headroom
  localparam int unsigned Z_W    = 25;  // angle accumulator, degrees in Q16
  localparam int unsigned FRAC_W = 16;  // fraction bits of the Q16 values
  localparam int unsigned MAG_W  = 7;   // whole degree magnitude, 0 to 90

  localparam logic [MAG_W-1:0] MAG_CAP   = 7'd89;
  localparam logic [MAG_W-1:0] MAG_RIGHT = 7'd90;
  localparam logic [5:0]       ASCII_ZERO = 6'h30;

  // Division by ten of values up to 90: multiply by 205, shift right by 11.
  localparam logic [7:0] DIV10_MUL   = 8'd205;
  localparam int unsigned DIV10_SHIFT = 11;
  localparam logic [3:0] DIGIT_BASE  = 4'd10;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } tilt_in_t;

  typedef struct packed {
    logic signed [7:0] tilt_degrees;
    logic              is_negative;
    logic [5:0]        tens_char;
    logic [5:0]        ones_char;
  } tilt_out_t;

  // Vertical term that travels beside the horizontal magnitude.
  typedef struct packed {
    logic        ay_neg;
    logic [15:0] ay_abs;
  } tilt_side_t;

  // round(atan(2^-i) * 180 / pi * 65536)
  function automatic logic signed [Z_W-1:0] atan_deg_q16(input int unsigned idx);
    logic signed [Z_W-1:0] val;
    case (idx)
      0:       val = 25'sd2949120;
      1:       val = 25'sd1740967;
      2:       val = 25'sd919879;
      3:       val = 25'sd466945;
      4:       val = 25'sd234379;
      5:       val = 25'sd117304;
      6:       val = 25'sd58666;
      7:       val = 25'sd29335;
      8:       val = 25'sd14668;
      9:       val = 25'sd7334;
      10:      val = 25'sd3667;
      11:      val = 25'sd1833;
      12:      val = 25'sd917;
      13:      val = 25'sd458;
      14:      val = 25'sd229;
      15:      val = 25'sd115;
      16:      val = 25'sd57;
      17:      val = 25'sd29;
      18:      val = 25'sd14;
      19:      val = 25'sd7;
      20:      val = 25'sd4;
      21:      val = 25'sd2;
      22:      val = 25'sd1;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tilt_sqrt.sv =====
// Horizontal magnitude pipeline: squares, sum, then a digit-by-digit square root
// that settles one result bit per stage. Depends on tilt_pkg.
`default_nettype none

module tilt_sqrt
  import tilt_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire tilt_in_t          data_i,
  output logic                   valid_o,
  output logic [ROOT_W-1:0]      root_o,
  output logic                   horiz_zero_o,
  output tilt_side_t             side_o
);

  localparam int unsigned NSTEP = ROOT_W;

  // Stage 1: squares.
  logic                 sq_valid_q;
  logic [SUM_W-1:0]     sq_x_q, sq_z_q;
  tilt_side_t           sq_side_q;
  logic signed [31:0]   prod_x, prod_z;
  tilt_side_t           side_in;

  // Stage 2: sum.
  logic                 sum_valid_q;
  logic [SUM_W-1:0]     sum_q;
  logic                 sum_zero_q;
  tilt_side_t           sum_side_q;
  logic [SUM_W:0]       sum_full;

  // Root stages.
  logic                 rt_valid_q [NSTEP];
  logic [REM_W-1:0]     rt_rem_q   [NSTEP];
  logic [ROOT_W-1:0]    rt_root_q  [NSTEP];
  logic [SUM_W-1:0]     rt_rad_q   [NSTEP];
  logic                 rt_zero_q  [NSTEP];
  tilt_side_t           rt_side_q  [NSTEP];

  assign prod_x = data_i.accel_x * data_i.accel_x;
  assign prod_z = data_i.accel_z * data_i.accel_z;
  assign side_in.ay_neg = data_i.accel_y[15];
  assign side_in.ay_abs = data_i.accel_y[15] ? (~data_i.accel_y + 16'd1) : data_i.accel_y;
  assign sum_full = {1'b0, sq_x_q} + {1'b0, sq_z_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_valid_q  <= 1'b0;
      sum_valid_q <= 1'b0;
    end else if (en_i) begin
      sq_valid_q  <= valid_i;
      sum_valid_q <= sq_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_x_q     <= prod_x;
      sq_z_q     <= prod_z;
      sq_side_q  <= side_in;
      sum_q      <= sum_full[SUM_W-1:0];
      sum_zero_q <= (sum_full == '0);
      sum_side_q <= sq_side_q;
    end
  end

  for (genvar j = 0; j < NSTEP; j++) begin : g_root
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [SUM_W-1:0]  rad_in;
    logic              val_in;
    logic              zero_in;
    tilt_side_t        side_st;
    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  diff;
    logic              take;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = sum_q;
      assign val_in  = sum_valid_q;
      assign zero_in = sum_zero_q;
      assign side_st = sum_side_q;
    end else begin : g_next
      assign rem_in  = rt_rem_q[j-1];
      assign root_in = rt_root_q[j-1];
      assign rad_in  = rt_rad_q[j-1];
      assign val_in  = rt_valid_q[j-1];
      assign zero_in = rt_zero_q[j-1];
      assign side_st = rt_side_q[j-1];
    end

    // Bring down the next two radicand bits and try to subtract 4 * root + 1.
    assign rem_sh = {rem_in, rad_in[SUM_W-1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign take   = (rem_sh >= trial);
    assign diff   = rem_sh - trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rt_valid_q[j] <= 1'b0;
      end else if (en_i) begin
        rt_valid_q[j] <= val_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rt_rem_q[j]  <= take ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
        rt_root_q[j] <= {root_in[ROOT_W-2:0], take};
        rt_rad_q[j]  <= {rad_in[SUM_W-3:0], 2'b00};
        rt_zero_q[j] <= zero_in;
        rt_side_q[j] <= side_st;
      end
    end
  end

  assign valid_o      = rt_valid_q[NSTEP-1];
  assign root_o       = rt_root_q[NSTEP-1];
  assign horiz_zero_o = rt_zero_q[NSTEP-1];
  assign side_o       = rt_side_q[NSTEP-1];

endmodule

`default_nettype wire

// ===== rtl/tilt_cordic.sv =====
// Vectoring CORDIC, one rotation per register stage, accumulating the angle
// in Q16 degrees. Depends on tilt_pkg.
`default_nettype none

module tilt_cordic
  import tilt_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire logic                  valid_i,
  input  wire logic [ROOT_W-1:0]     root_i,
  input  wire logic                  horiz_zero_i,
  input  wire tilt_side_t            side_i,
  output logic                       valid_o,
  output logic signed [Z_W-1:0]      angle_o,
  output logic                       horiz_zero_o,
  output tilt_side_t                 side_o
);

  logic                   cd_valid_q [CORDIC_STEPS];
  logic signed [XY_W-1:0] cd_x_q     [CORDIC_STEPS];
  logic signed [XY_W-1:0] cd_y_q     [CORDIC_STEPS];
  logic signed [Z_W-1:0]  cd_z_q     [CORDIC_STEPS];
  logic                   cd_zero_q  [CORDIC_STEPS];
  tilt_side_t             cd_side_q  [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [XY_W-1:0] x_in, y_in, x_sh, y_sh;
    logic signed [Z_W-1:0]  z_in;
    logic                   val_in, zero_in;
    tilt_side_t             side_st;
    logic signed [Z_W-1:0]  step_ang;

    if (i == 0) begin : g_first
      // Start from (r, |ay| * 2^16) with a zero angle.
      assign x_in    = $signed({{(XY_W-ROOT_W){1'b0}}, root_i});
      assign y_in    = $signed({{(XY_W-16-FRAC_W){1'b0}}, side_i.ay_abs, {FRAC_W{1'b0}}});
      assign z_in    = '0;
      assign val_in  = valid_i;
      assign zero_in = horiz_zero_i;
      assign side_st = side_i;
    end else begin : g_next
      assign x_in    = cd_x_q[i-1];
      assign y_in    = cd_y_q[i-1];
      assign z_in    = cd_z_q[i-1];
      assign val_in  = cd_valid_q[i-1];
      assign zero_in = cd_zero_q[i-1];
      assign side_st = cd_side_q[i-1];
    end

    assign x_sh     = x_in >>> i;
    assign y_sh     = y_in >>> i;
    assign step_ang = atan_deg_q16(i);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cd_valid_q[i] <= 1'b0;
      end else if (en_i) begin
        cd_valid_q[i] <= val_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (y_in == '0) begin
          cd_x_q[i] <= x_in;
          cd_y_q[i] <= y_in;
          cd_z_q[i] <= z_in;
        end else if (y_in[XY_W-1]) begin
          cd_x_q[i] <= x_in - y_sh;
          cd_y_q[i] <= y_in + x_sh;
          cd_z_q[i] <= z_in - step_ang;
        end else begin
          cd_x_q[i] <= x_in + y_sh;
          cd_y_q[i] <= y_in - x_sh;
          cd_z_q[i] <= z_in + step_ang;
        end
        cd_zero_q[i] <= zero_in;
        cd_side_q[i] <= side_st;
      end
    end
  end

  assign valid_o      = cd_valid_q[CORDIC_STEPS-1];
  assign angle_o      = cd_z_q[CORDIC_STEPS-1];
  assign horiz_zero_o = cd_zero_q[CORDIC_STEPS-1];
  assign side_o       = cd_side_q[CORDIC_STEPS-1];

endmodule

`default_nettype wire

// ===== rtl/tilt_format.sv =====
// Turns the Q16 angle into whole degrees, applies the sign and builds the
// ASCII tens and ones digits, in two register stages. Depends on tilt_pkg.
`default_nettype none

module tilt_format
  import tilt_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire logic                  valid_i,
  input  wire logic signed [Z_W-1:0] angle_i,
  input  wire logic                  horiz_zero_i,
  input  wire tilt_side_t            side_i,
  output logic                       valid_o,
  output tilt_out_t                  data_o
);

  localparam int unsigned DEG_W = Z_W - FRAC_W;

  logic               mg_valid_q;
  logic [MAG_W-1:0]   mg_mag_q;
  logic               mg_neg_q;
  logic               fm_valid_q;
  tilt_out_t          fm_data_q;

  logic [DEG_W-1:0]   deg;
  logic [MAG_W-1:0]   mag_d;
  logic [14:0]        tens_prod;
  logic [3:0]         tens, ones;
  logic [MAG_W-1:0]   tens_x10;
  logic [MAG_W-1:0]   ones_full;
  logic               neg;
  tilt_out_t          fm_data_d;

  assign deg = angle_i[Z_W-1:FRAC_W];

  always_comb begin
    if (horiz_zero_i) begin
      // Straight up or down, or no acceleration at all.
      mag_d = (side_i.ay_abs != '0) ? MAG_RIGHT : '0;
    end else if (angle_i[Z_W-1]) begin
      mag_d = '0;
    end else if (deg > DEG_W'(MAG_CAP)) begin
      mag_d = MAG_CAP;
    end else begin
      mag_d = deg[MAG_W-1:0];
    end
  end

  assign tens_prod = mg_mag_q * DIV10_MUL;
  assign tens      = tens_prod[DIV10_SHIFT +: 4];
  assign tens_x10  = MAG_W'(tens) * MAG_W'(DIGIT_BASE);
  assign ones_full = mg_mag_q - tens_x10;
  assign ones      = ones_full[3:0];
  assign neg       = mg_neg_q && (mg_mag_q != '0);

  always_comb begin
    fm_data_d.tilt_degrees = neg ? -$signed({1'b0, mg_mag_q}) : $signed({1'b0, mg_mag_q});
    fm_data_d.is_negative  = neg;
    fm_data_d.tens_char    = ASCII_ZERO + {2'b00, tens};
    fm_data_d.ones_char    = ASCII_ZERO + {2'b00, ones};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mg_valid_q <= 1'b0;
      fm_valid_q <= 1'b0;
    end else if (en_i) begin
      mg_valid_q <= valid_i;
      fm_valid_q <= mg_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mg_mag_q  <= mag_d;
      mg_neg_q  <= side_i.ay_neg;
      fm_data_q <= fm_data_d;
    end
  end

  assign valid_o = fm_valid_q;
  assign data_o  = fm_data_q;

endmodule

`default_nettype wire

// ===== rtl/accel_tilt_angle_ascii_core.sv =====
// Top level of the accelerometer tilt angle core: square root, CORDIC and
// digit pipelines followed by an output register with a skid stage.
// Depends on tilt_pkg, tilt_sqrt, tilt_cordic and tilt_format.
//
//   Channel   Direction   Handshake                 Payload
//   in        sink        in_valid_i / in_stall_o   tilt_in_t  (accel_x/y/z)
//   out       source      out_valid_o / out_stall_i tilt_out_t (angle, sign, digits)
//
// One sample enters per cycle while in_stall_o is low. The stages are the squares and
// sum stages, 32 square root stages, one stage per CORDIC step, the magnitude and
// digit formatting stages, and one output register.
// Reset clears only the valid bits; no clearing pass is needed.
// When the output stalls, the transfer already in flight lands in the skid
// stage and in_stall_o rises until that stage drains; nothing is lost or repeated.
`default_nettype none

module accel_tilt_angle_ascii_core
  import tilt_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire tilt_in_t   in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output tilt_out_t       out_data_o
);

  logic                  en;
  logic                  sq_valid;
  logic [ROOT_W-1:0]     sq_root;
  logic                  sq_zero;
  tilt_side_t            sq_side;
  logic                  cd_valid;
  logic signed [Z_W-1:0] cd_angle;
  logic                  cd_zero;
  tilt_side_t            cd_side;
  logic                  fm_valid;
  tilt_out_t             fm_data;

  logic                  out_valid_q, skid_valid_q;
  tilt_out_t             out_data_q, skid_data_q;

  // The whole pipeline moves together while the skid stage is empty.
  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  tilt_sqrt u_sqrt (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (in_valid_i),
    .data_i       (in_data_i),
    .valid_o      (sq_valid),
    .root_o       (sq_root),
    .horiz_zero_o (sq_zero),
    .side_o       (sq_side)
  );

  tilt_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (sq_valid),
    .root_i       (sq_root),
    .horiz_zero_i (sq_zero),
    .side_i       (sq_side),
    .valid_o      (cd_valid),
    .angle_o      (cd_angle),
    .horiz_zero_o (cd_zero),
    .side_o       (cd_side)
  );

  tilt_format u_format (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (cd_valid),
    .angle_i      (cd_angle),
    .horiz_zero_i (cd_zero),
    .side_i       (cd_side),
    .valid_o      (fm_valid),
    .data_o       (fm_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= fm_valid;
      end
    end else if (fm_valid && en) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      out_data_q <= skid_valid_q ? skid_data_q : fm_data;
    end else if (fm_valid && en) begin
      skid_data_q <= fm_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for accel_tilt_angle_ascii_core: random and directed samples with
// random gaps and output stalls, checked against an in-bench CORDIC tilt predictor.
// Depends on tilt_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;
  import tilt_pkg::*;

  localparam int unsigned STEPS          = CORDIC_STEPS_DEF;
  localparam int unsigned LATENCY        = 37 + STEPS;
  localparam int          N_RANDOM       = 1930;
  localparam int          WATCHDOG_LIMIT = 5000;

  // round(atan(2^-i) * 180 / pi * 65536)
  localparam longint ATAN_Q16 [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  tilt_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  tilt_out_t out_data;

  tilt_in_t  sample_q[$];
  tilt_out_t angle_q[$];

  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_neg = 0;
  int n_right = 0;
  int n_zero = 0;
  int idle_cycles = 0;

  accel_tilt_angle_ascii_core #(.CORDIC_STEPS(STEPS)) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always #10 clk_i = ~clk_i;

  // Expected tilt, sign and ASCII digits for one sample.
  function automatic tilt_out_t tilt_predict(input tilt_in_t s);
    longint            ax, ay, az, ay_abs, x, y, z, xs, ys;
    longint unsigned   sum, rem, root, bitv;
    int                mag;
    bit                neg;
    tilt_out_t         r;
    ax = s.accel_x;
    ay = s.accel_y;
    az = s.accel_z;
    ay_abs = (ay < 0) ? -ay : ay;
    sum = longint'(ax * ax) + longint'(az * az);
    if (sum == 0) begin
      mag = (ay_abs != 0) ? 90 : 0;
    end else begin
      // Integer square root of sum * 2^32, i.e. the horizontal magnitude in Q16.
      rem  = sum << 32;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (rem >= root + bitv) begin
          rem  = rem - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      x = longint'(root);
      y = ay_abs * 65536;
      z = 0;
      for (int i = 0; i < STEPS && i < 24; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x = x + ys;
          y = y - xs;
          z = z + ATAN_Q16[i];
        end else if (y < 0) begin
          x = x - ys;
          y = y + xs;
          z = z - ATAN_Q16[i];
        end
      end
      if (z < 0) z = 0;
      mag = int'(z >>> 16);
      if (mag > 89) mag = 89;
    end
    neg = (ay < 0) && (mag != 0);
    r.tilt_degrees = neg ? 8'(-mag) : 8'(mag);
    r.is_negative  = neg;
    r.tens_char    = ASCII_ZERO + 6'(mag / 10);
    r.ones_char    = ASCII_ZERO + 6'(mag % 10);
    return r;
  endfunction

  // Signed count spread over [-2^k, 2^k - 1].
  function automatic logic signed [15:0] rand_scaled(input int k);
    int span;
    span = 1 << k;
    return 16'($urandom_range(0, 2 * span - 1) - span);
  endfunction

  function automatic logic signed [15:0] rand_extreme();
    case ($urandom_range(0, 5))
      0:       return -16'sd32768;
      1:       return -16'sd32767;
      2:       return -16'sd1;
      3:       return 16'sd0;
      4:       return 16'sd1;
      default: return 16'sd32767;
    endcase
  endfunction

  function automatic tilt_in_t make_sample(input int ax, input int ay, input int az);
    tilt_in_t s;
    s.accel_x = 16'(ax);
    s.accel_y = 16'(ay);
    s.accel_z = 16'(az);
    return s;
  endfunction

  // Driver: one transfer per item, with a drawn gap before each following item.
  int  drv_gap = 0;
  bit  drv_burst = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      drv_gap  = 0;
    end else begin
      if (in_valid && !in_stall) begin
        angle_q.push_back(tilt_predict(in_data));
        n_sent++;
        if ($urandom_range(0, 63) == 0) drv_burst = !drv_burst;
        drv_gap = drv_burst ? 0 : $urandom_range(0, 7);
      end
      if (!in_valid || !in_stall) begin
        if (drv_gap > 0) begin
          drv_gap--;
          in_valid <= 1'b0;
        end else if (sample_q.size() > 0) begin
          in_valid <= 1'b1;
          in_data  <= sample_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer and draws a stall after it.
  int  mon_stall = 0;
  bit  mon_burst = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    tilt_out_t exp_r;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      mon_stall = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (angle_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, actual %p", $time, out_data);
        end else begin
          exp_r = angle_q.pop_front();
          n_checked++;
          if (exp_r.is_negative) n_neg++;
          if (exp_r.tilt_degrees == 8'sd90 || exp_r.tilt_degrees == -8'sd90) n_right++;
          if (exp_r.tilt_degrees == 8'sd0) n_zero++;
          if (out_data.tilt_degrees !== exp_r.tilt_degrees) begin
            errors++;
            $display("%0t: tilt_degrees expected %0d actual %0d", $time,
                     exp_r.tilt_degrees, out_data.tilt_degrees);
          end
          if (out_data.is_negative !== exp_r.is_negative) begin
            errors++;
            $display("%0t: is_negative expected %0b actual %0b", $time,
                     exp_r.is_negative, out_data.is_negative);
          end
          if (out_data.tens_char !== exp_r.tens_char) begin
            errors++;
            $display("%0t: tens_char expected %h actual %h", $time,
                     exp_r.tens_char, out_data.tens_char);
          end
          if (out_data.ones_char !== exp_r.ones_char) begin
            errors++;
            $display("%0t: ones_char expected %h actual %h", $time,
                     exp_r.ones_char, out_data.ones_char);
          end
        end
        if ($urandom_range(0, 63) == 0) mon_burst = !mon_burst;
        mon_stall = mon_burst ? 0 : $urandom_range(0, 7);
      end
      if (mon_stall > 0) begin
        mon_stall--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles without any transfer on either side.
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired at %0t", $time);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int kind;
    // Axis extremes, the right-angle and all-zero cases, the 89 degree cap,
    // and tiny negative tilts that round to zero.
    sample_q.push_back(make_sample(0, 0, 0));
    sample_q.push_back(make_sample(0, 32767, 0));
    sample_q.push_back(make_sample(0, -32768, 0));
    sample_q.push_back(make_sample(0, -1, 0));
    sample_q.push_back(make_sample(0, 1, 0));
    sample_q.push_back(make_sample(32767, 0, 0));
    sample_q.push_back(make_sample(0, 0, -32768));
    sample_q.push_back(make_sample(-32768, 0, -32768));
    sample_q.push_back(make_sample(-32768, -32768, -32768));
    sample_q.push_back(make_sample(-32768, 32767, -32768));
    sample_q.push_back(make_sample(1, 32767, 0));
    sample_q.push_back(make_sample(0, -32768, -1));
    sample_q.push_back(make_sample(32767, -1, 32767));
    sample_q.push_back(make_sample(32767, 1, 32767));
    sample_q.push_back(make_sample(1, 1, 0));
    sample_q.push_back(make_sample(-1, -1, 0));
    sample_q.push_back(make_sample(0, 1, -1));
    sample_q.push_back(make_sample(100, -173, 0));
    sample_q.push_back(make_sample(-1000, 577, 0));
    sample_q.push_back(make_sample(0, 0, 1));
    for (int n = 0; n < N_RANDOM; n++) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2, 3, 4: sample_q.push_back(make_sample(rand_scaled($urandom_range(0, 15)),
                                                      rand_scaled($urandom_range(0, 15)),
                                                      rand_scaled($urandom_range(0, 15))));
        5: sample_q.push_back(make_sample(rand_scaled(15), rand_scaled(15), rand_scaled(15)));
        6: sample_q.push_back(make_sample(rand_scaled(1), rand_scaled(15), rand_scaled(1)));
        7: begin
          if ($urandom_range(0, 1) == 0)
            sample_q.push_back(make_sample(0, rand_scaled(15), rand_scaled(15)));
          else
            sample_q.push_back(make_sample(rand_scaled(15), rand_scaled(15), 0));
        end
        default: sample_q.push_back(make_sample(rand_extreme(), rand_extreme(),
                                                rand_extreme()));
      endcase
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (sample_q.size() != 0 || in_valid) @(posedge clk_i);
    while (angle_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);

    $display("Sent %0d samples and checked %0d tilt results under random gaps and stalls.",
             n_sent, n_checked);
    $display("Results included %0d negative, %0d at +/-90 and %0d zero angles.",
             n_neg, n_right, n_zero);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
